FILE: hdl/rmq_pkg.sv
// shared constants for the rotation matrix to quaternion core
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int DATA_W = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;
  // signed width of the off-diagonal sums and differences
  localparam int NUM_W = 20;
  // magnitude width of those sums and differences
  localparam int MAG_W = 19;

  localparam logic [1:0] PATH_TRACE = 2'd0;
  localparam logic [1:0] PATH_COL0 = 2'd1;
  localparam logic [1:0] PATH_COL1 = 2'd2;
  localparam logic [1:0] PATH_COL2 = 2'd3;

  typedef struct packed {
    logic [1:0] path;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
  } root_side_t;

  typedef struct packed {
    logic [1:0] path;
    logic degen;
    logic [DATA_W-1:0] quar;
    logic [2:0] neg;
  } div_side_t;

endpackage

FILE: hdl/rmq_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module rmq_sqrt_pipe #(
  parameter int RB = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [2*RB-1:0] radicand,
  output logic [RB-1:0] root
);

  logic [RB+1:0]   rem_w  [0:RB];
  logic [RB-1:0]   root_w [0:RB];
  logic [2*RB-1:0] rad_w  [0:RB];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = radicand;

  for (genvar k = 0; k < RB; k++) begin : g_step
    logic [RB+1:0] cand;
    logic [RB+1:0] trial;
    logic          ge;
    always_comb begin
      cand  = {rem_w[k][RB-1:0], rad_w[k][2*RB-1:2*RB-2]};
      trial = {root_w[k], 2'b01};
      ge    = cand >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_w[k+1]  <= ge ? cand - trial : cand;
        root_w[k+1] <= {root_w[k][RB-2:0], ge};
        rad_w[k+1]  <= {rad_w[k][2*RB-3:0], 2'b00};
      end
    end
  end

  assign root = root_w[RB];

endmodule

FILE: hdl/rmq_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module rmq_div_pipe #(
  parameter int DW = 35,
  parameter int SW = 26
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic [DW-1:0] quotient
);

  logic [SW-1:0] rem_w [0:DW];
  logic [DW-1:0] dvd_w [0:DW];
  logic [DW-1:0] quo_w [0:DW];
  logic [SW-1:0] den_w [0:DW];

  assign rem_w[0] = '0;
  assign dvd_w[0] = dividend;
  assign quo_w[0] = '0;
  assign den_w[0] = divisor;

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [SW:0] cand;
    logic [SW:0] diff;
    logic        ge;
    always_comb begin
      cand = {rem_w[k], dvd_w[k][DW-1]};
      diff = cand - {1'b0, den_w[k]};
      ge   = cand >= {1'b0, den_w[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_w[k+1] <= ge ? diff[SW-1:0] : cand[SW-1:0];
        dvd_w[k+1] <= {dvd_w[k][DW-2:0], 1'b0};
        quo_w[k+1] <= {quo_w[k][DW-2:0], ge};
        den_w[k+1] <= den_w[k];
      end
    end
  end

  assign quotient = quo_w[DW];

endmodule

FILE: hdl/rotation_matrix_to_quaternion_core.sv
// top level: rotation matrix to unit quaternion, fully pipelined
// stages: input register, square root stages, divider stages, output register
// RB = ceil((max(FRAC_BITS,19)+1+FRAC_BITS)/2) root bits, DW = 19+FRAC_BITS quotient bits, one bit per stage
// throughput: one matrix per cycle; a stalled result freezes the whole pipeline
// reset: synchronous, clears only the stage valid bits
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_stall,
  input  logic signed [DATA_W-1:0] m00,
  input  logic signed [DATA_W-1:0] m01,
  input  logic signed [DATA_W-1:0] m02,
  input  logic signed [DATA_W-1:0] m10,
  input  logic signed [DATA_W-1:0] m11,
  input  logic signed [DATA_W-1:0] m12,
  input  logic signed [DATA_W-1:0] m20,
  input  logic signed [DATA_W-1:0] m21,
  input  logic signed [DATA_W-1:0] m22,
  output logic quat_valid,
  input  logic quat_stall,
  output logic signed [DATA_W-1:0] quat_x,
  output logic signed [DATA_W-1:0] quat_y,
  output logic signed [DATA_W-1:0] quat_z,
  output logic signed [DATA_W-1:0] quat_w,
  output logic [1:0] path_taken,
  output logic degenerate
);

  // radicand magnitude, signed trace width, root and divider sizes
  localparam int TW   = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 1;
  localparam int TSW  = TW + 1;
  localparam int RADW = TW + FRAC_BITS;
  localparam int RB   = (RADW + 1) / 2;
  localparam int SW   = RB + 1;
  localparam int DW   = MAG_W + FRAC_BITS;

  // whole pipeline moves together; it holds only while a result waits
  logic adv;
  assign adv = !quat_valid || !quat_stall;
  assign mat_stall = !adv;

  // ---------------- stage 0: trace, path choice, numerators ----------------
  logic signed [TSW-1:0] one_s, e00, e11, e22, t_tr, t_sel;
  logic signed [NUM_W-1:0] n21m, n02m, n10m, n10p, n02p, n21p;
  logic [1:0] path_c;
  root_side_t side_c;

  always_comb begin
    one_s = TSW'(1) <<< FRAC_BITS;
    e00 = TSW'(m00);
    e11 = TSW'(m11);
    e22 = TSW'(m22);
    t_tr = one_s + e00 + e11 + e22;
    n21m = NUM_W'(m21) - NUM_W'(m12);
    n02m = NUM_W'(m02) - NUM_W'(m20);
    n10m = NUM_W'(m10) - NUM_W'(m01);
    n10p = NUM_W'(m10) + NUM_W'(m01);
    n02p = NUM_W'(m02) + NUM_W'(m20);
    n21p = NUM_W'(m21) + NUM_W'(m12);
    // positive trace first, then the largest diagonal, ties to the later column
    if (t_tr > 0) begin
      path_c = PATH_TRACE;
      t_sel  = t_tr;
    end else if (m00 > m11 && m00 > m22) begin
      path_c = PATH_COL0;
      t_sel  = one_s + e00 - e11 - e22;
    end else if (m11 > m22) begin
      path_c = PATH_COL1;
      t_sel  = one_s + e11 - e00 - e22;
    end else begin
      path_c = PATH_COL2;
      t_sel  = one_s + e22 - e00 - e11;
    end
    side_c.path = path_c;
    // three divided terms, in output order with the quarter term left out
    case (path_c)
      PATH_TRACE: begin
        side_c.n0 = n21m; side_c.n1 = n02m; side_c.n2 = n10m;
      end
      PATH_COL0: begin
        side_c.n0 = n10p; side_c.n1 = n02p; side_c.n2 = n21m;
      end
      PATH_COL1: begin
        side_c.n0 = n10p; side_c.n1 = n21p; side_c.n2 = n02m;
      end
      default: begin
        side_c.n0 = n02p; side_c.n1 = n21p; side_c.n2 = n10m;
      end
    endcase
  end

  logic          s0_valid;
  logic [TW-1:0] s0_rad;
  root_side_t    a_side [0:RB];
  logic          a_vld  [0:RB];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= mat_valid;
    end
  end

  // negative radicand clamps to zero
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_rad    <= t_sel[TSW-1] ? '0 : t_sel[TW-1:0];
      a_side[0] <= side_c;
    end
  end

  // ---------------- square root stages ----------------
  logic [2*RB-1:0] sq_in;
  logic [RB-1:0]   root;

  assign sq_in = (2*RB)'({s0_rad, {FRAC_BITS{1'b0}}});

  rmq_sqrt_pipe #(.RB(RB)) u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (sq_in),
    .root     (root)
  );

  // side data rides along with the root stages
  assign a_vld[0] = s0_valid;
  for (genvar k = 1; k <= RB; k++) begin : g_aside
    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld[k] <= 1'b0;
      end else if (adv) begin
        a_vld[k] <= a_vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        a_side[k] <= a_side[k-1];
      end
    end
  end

  // ---------------- divider feed: S = 2r, magnitudes, quarter term ----------------
  logic [SW-1:0] s_val;
  logic [RB-1:0] quar_raw;
  logic signed [NUM_W-1:0] nsel [0:2];
  logic [MAG_W-1:0] mag [0:2];
  logic [DW-1:0] dvd [0:2];
  logic [DW-1:0] quo [0:2];
  div_side_t b_side [0:DW];
  logic      b_vld  [0:DW];

  always_comb begin
    s_val    = {root, 1'b0};
    quar_raw = root >> 1;
    nsel[0]  = a_side[RB].n0;
    nsel[1]  = a_side[RB].n1;
    nsel[2]  = a_side[RB].n2;
    b_side[0].path  = a_side[RB].path;
    b_side[0].degen = (root == '0);
    b_side[0].quar  = (32'(quar_raw) > 32'(OUT_MAX)) ? DATA_W'(OUT_MAX)
                                                     : DATA_W'(quar_raw);
    for (int i = 0; i < 3; i++) begin
      mag[i] = nsel[i][NUM_W-1] ? MAG_W'(-nsel[i]) : MAG_W'(nsel[i]);
      dvd[i] = {mag[i], {FRAC_BITS{1'b0}}};
      b_side[0].neg[i] = nsel[i][NUM_W-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    rmq_div_pipe #(.DW(DW), .SW(SW)) u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (dvd[i]),
      .divisor  (s_val),
      .quotient (quo[i])
    );
  end

  assign b_vld[0] = a_vld[RB];
  for (genvar k = 1; k <= DW; k++) begin : g_bside
    always_ff @(posedge clk) begin
      if (rst) begin
        b_vld[k] <= 1'b0;
      end else if (adv) begin
        b_vld[k] <= b_vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        b_side[k] <= b_side[k-1];
      end
    end
  end

  // ---------------- sign, saturation, component placement ----------------
  logic signed [DATA_W-1:0] qs [0:2];
  logic signed [DATA_W-1:0] qr;
  logic signed [DATA_W-1:0] x_next, y_next, z_next, w_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!b_side[DW].neg[i]) begin
        qs[i] = (quo[i] > DW'(OUT_MAX)) ? DATA_W'(OUT_MAX) : DATA_W'(quo[i]);
      end else begin
        qs[i] = (quo[i] > DW'(-OUT_MIN)) ? DATA_W'(OUT_MIN) : DATA_W'(-quo[i]);
      end
    end
    qr = b_side[DW].quar;
    case (b_side[DW].path)
      PATH_TRACE: begin
        x_next = qs[0]; y_next = qs[1]; z_next = qs[2]; w_next = qr;
      end
      PATH_COL0: begin
        x_next = qr; y_next = qs[0]; z_next = qs[1]; w_next = qs[2];
      end
      PATH_COL1: begin
        x_next = qs[0]; y_next = qr; z_next = qs[1]; w_next = qs[2];
      end
      default: begin
        x_next = qs[0]; y_next = qs[1]; z_next = qr; w_next = qs[2];
      end
    endcase
    // zero S forces all components to zero
    if (b_side[DW].degen) begin
      x_next = '0; y_next = '0; z_next = '0; w_next = '0;
    end
  end

  // output register is the last pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (adv) begin
      quat_valid <= b_vld[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_x     <= x_next;
      quat_y     <= y_next;
      quat_z     <= z_next;
      quat_w     <= w_next;
      path_taken <= b_side[DW].path;
      degenerate <= b_side[DW].degen;
    end
  end

  // degenerate result carries all-zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    quat_valid && degenerate |->
      quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
    else $error("degenerate result with nonzero component");

  // a positive trace always gives a nonzero root
  a_trace_nondegen: assert property (@(posedge clk) disable iff (rst)
    quat_valid && path_taken == PATH_TRACE |-> !degenerate)
    else $error("trace path flagged degenerate");

  // the quarter term sits in the chosen slot and is never negative
  a_quarter_sign: assert property (@(posedge clk) disable iff (rst)
    quat_valid && !degenerate |->
      (path_taken != PATH_TRACE || !quat_w[DATA_W-1]) &&
      (path_taken != PATH_COL0 || !quat_x[DATA_W-1]) &&
      (path_taken != PATH_COL1 || !quat_y[DATA_W-1]) &&
      (path_taken != PATH_COL2 || !quat_z[DATA_W-1]))
    else $error("quarter term negative");

endmodule
